>>> rtl/smeu_pkg.sv
// Shared types and constants of the stack machine execute unit.
`default_nettype none
package smeu_pkg;

	localparam int PROG_ADDR_BITS = 12;

	localparam logic [15:0] STEP_LIMIT_RESET = 16'd1000;
	localparam logic [15:0] STEP_COUNT_MAX   = 16'hFFFF;

	// Register index within the configuration space
	localparam logic REG_STEP_LIMIT = 1'b0;

	typedef enum logic [4:0] {
		OP_PUSH = 5'd0,  OP_POP  = 5'd1,  OP_DUP  = 5'd2,  OP_ADD  = 5'd3,
		OP_SUB  = 5'd4,  OP_MUL  = 5'd5,  OP_DIV  = 5'd6,  OP_JMP  = 5'd7,
		OP_JIT  = 5'd8,  OP_JIF  = 5'd9,  OP_CALL = 5'd10, OP_RET  = 5'd11,
		OP_EQ   = 5'd12, OP_GT   = 5'd13, OP_GE   = 5'd14, OP_LT   = 5'd15,
		OP_LE   = 5'd16, OP_NE   = 5'd17, OP_STO  = 5'd18, OP_RCL  = 5'd19,
		OP_END  = 5'd20, OP_PRN  = 5'd21, OP_STL  = 5'd22, OP_RCE  = 5'd23,
		OP_ALC  = 5'd24, OP_FRE  = 5'd25
	} opcode_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_DIV_ZERO  = 3'd1,
		ERR_UNDERFLOW = 3'd2,
		ERR_OVERFLOW  = 3'd3,
		ERR_CALL      = 3'd4,
		ERR_INDEX     = 3'd5,
		ERR_BUDGET    = 3'd6,
		ERR_OPCODE    = 3'd7
	} error_t;

	typedef struct packed {
		logic [4:0]         operation;
		logic signed [31:0] argument;
	} instr_t;

	typedef struct packed {
		logic [PROG_ADDR_BITS-1:0] next_address;
		logic                      print_valid;
		logic signed [31:0]        print_value;
		logic                      halted;
		logic [2:0]                error_code;
	} result_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic rd_a;
		logic rd_b;
		logic div_start;
		logic commit;
		logic wr2;
	} ctrl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_free;
		logic need_wr2;
	} ctrl_sts_t;

endpackage
`default_nettype wire

>>> rtl/smeu_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
`default_nettype none
module smeu_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic      [31:0] quotient,
	output logic             done
);

	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic        neg_q;
	logic [5:0]  cnt_q;

	logic [32:0] r_sh;
	logic [32:0] diff;

	assign r_sh = {rem_q[31:0], quo_q[31]};
	assign diff = r_sh - {1'b0, dvs_q};

	// Count down the remaining quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	// Restoring shift-subtract on magnitudes
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 33'd0;
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			dvs_q <= divisor[31] ? (32'd0 - divisor) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (cnt_q != 6'd0) begin
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= r_sh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = (cnt_q == 6'd0);
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule
`default_nettype wire

>>> rtl/smeu_ctrl.sv
// Sequencer that steps one instruction through read, divide, commit and write-back.
`default_nettype none
module smeu_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	output logic                      cmd_ready,
	input  wire smeu_pkg::ctrl_sts_t  sts,
	output smeu_pkg::ctrl_cmd_t       ctl
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD_A = 7'b0000010,
		S_RD_B = 7'b0000100,
		S_PREP = 7'b0001000,
		S_DIV  = 7'b0010000,
		S_EXEC = 7'b0100000,
		S_WR2  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nx;

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.capture = 1'b1;
					state_nx    = S_RD_A;
				end
			end
			S_RD_A: begin
				ctl.rd_a = 1'b1;
				state_nx = S_RD_B;
			end
			S_RD_B: begin
				ctl.rd_b = 1'b1;
				state_nx = S_PREP;
			end
			S_PREP: begin
				if (sts.need_div) begin
					ctl.div_start = 1'b1;
					state_nx      = S_DIV;
				end else begin
					state_nx = S_EXEC;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.out_free) begin
					ctl.commit = 1'b1;
					state_nx   = sts.need_wr2 ? S_WR2 : S_IDLE;
				end
			end
			S_WR2: begin
				ctl.wr2  = 1'b1;
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign cmd_ready = (state_q == S_IDLE);

endmodule
`default_nettype wire

>>> rtl/smeu_dpath.sv
// Datapath: stacks, data memory, machine registers, execute logic and result register.
`default_nettype none
module smeu_dpath #(
	parameter int DATA_STACK_DEPTH = 64,
	parameter int CALL_STACK_DEPTH = 64,
	parameter int MEM_WORDS        = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire smeu_pkg::ctrl_cmd_t  ctl,
	output smeu_pkg::ctrl_sts_t       sts,
	input  wire smeu_pkg::instr_t     cmd,
	input  wire logic [15:0]          step_limit,
	output smeu_pkg::result_t         rsp,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready
);

	localparam int PAB = smeu_pkg::PROG_ADDR_BITS;
	localparam int DAW = $clog2(DATA_STACK_DEPTH);
	localparam int DTW = $clog2(DATA_STACK_DEPTH + 1);
	localparam int CAW = $clog2(CALL_STACK_DEPTH);
	localparam int CTW = $clog2(CALL_STACK_DEPTH + 1);
	localparam int MAW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

	// Machine state
	logic [DTW-1:0] dt_q;
	logic [CTW-1:0] ct_q;
	logic [31:0]    fb_q;
	logic [PAB-1:0] ip_q;
	logic [15:0]    sc_q;
	logic           stopped_q;

	logic [31:0] ds_mem [DATA_STACK_DEPTH];
	logic [31:0] cs_mem [CALL_STACK_DEPTH];
	logic [CALL_STACK_DEPTH-1:0] cs_vld_q;
	logic [31:0] dm_q [MEM_WORDS];

	// Instruction and operand registers
	logic [4:0]  op_q;
	logic [31:0] arg_q;
	logic [31:0] ds_t_q;
	logic [31:0] ds_s_q;
	logic [31:0] cs_t_q;
	logic [31:0] cs_s_q;
	logic [CAW-1:0] pend_wa_q;
	logic [31:0]    pend_wd_q;

	smeu_pkg::result_t rsp_q;
	logic              rsp_valid_q;

	// Divider
	logic [31:0] quotient;
	logic        div_done;

	smeu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (ds_s_q),
		.divisor  (ds_t_q),
		.quotient (quotient),
		.done     (div_done)
	);

	// Operand checks
	smeu_pkg::opcode_t op;
	logic [33:0]    fidx;
	logic           fok;
	logic           mok;
	logic           dt_full;
	logic           budget_ok;
	logic [DTW-1:0] dt_m1;
	logic [DTW-1:0] dt_m2;
	logic [CTW-1:0] ct_m1;
	logic [CTW-1:0] ct_m2;
	logic [31:0]    dm_rd;

	assign op        = smeu_pkg::opcode_t'(op_q);
	assign fidx      = {2'b00, fb_q} + {{2{arg_q[31]}}, arg_q};
	assign fok       = !fidx[33] && (fidx[32:0] < 33'(CALL_STACK_DEPTH));
	assign mok       = !arg_q[31] && (arg_q[30:0] < 31'(MEM_WORDS));
	assign dt_full   = (dt_q >= DTW'(DATA_STACK_DEPTH));
	assign budget_ok = (sc_q < step_limit);
	assign dt_m1     = dt_q - DTW'(1);
	assign dt_m2     = dt_q - DTW'(2);
	assign ct_m1     = ct_q - CTW'(1);
	assign ct_m2     = ct_q - CTW'(2);
	assign dm_rd     = dm_q[arg_q[MAW-1:0]];

	// Read addresses for the operand fetch states RD_A and RD_B
	logic [DAW-1:0] ds_ra;
	logic [CAW-1:0] cs_ra;

	always_comb begin
		if (ctl.rd_a) begin
			ds_ra = dt_m1[DAW-1:0];
			cs_ra = (op == smeu_pkg::OP_RCE) ? fidx[CAW-1:0] : ct_m1[CAW-1:0];
		end else begin
			ds_ra = dt_m2[DAW-1:0];
			cs_ra = ct_m2[CAW-1:0];
		end
	end

	// Binary operation on second (s) against top (t)
	logic [31:0] mul_lo;
	logic [31:0] bin_r;

	assign mul_lo = ds_s_q * ds_t_q;

	always_comb begin
		case (op)
			smeu_pkg::OP_ADD: bin_r = ds_s_q + ds_t_q;
			smeu_pkg::OP_SUB: bin_r = ds_s_q - ds_t_q;
			smeu_pkg::OP_MUL: bin_r = mul_lo;
			smeu_pkg::OP_DIV: bin_r = quotient;
			smeu_pkg::OP_EQ:  bin_r = {31'd0, ds_s_q == ds_t_q};
			smeu_pkg::OP_GT:  bin_r = {31'd0, $signed(ds_s_q) > $signed(ds_t_q)};
			smeu_pkg::OP_GE:  bin_r = {31'd0, $signed(ds_s_q) >= $signed(ds_t_q)};
			smeu_pkg::OP_LT:  bin_r = {31'd0, $signed(ds_s_q) < $signed(ds_t_q)};
			smeu_pkg::OP_LE:  bin_r = {31'd0, $signed(ds_s_q) <= $signed(ds_t_q)};
			default:          bin_r = {31'd0, ds_s_q != ds_t_q};
		endcase
	end

	// Execute decision
	smeu_pkg::error_t err;
	logic [PAB-1:0] ip_inc;
	logic [PAB-1:0] ip_nx;
	logic           halt_now;
	logic           ds_we;
	logic [DAW-1:0] ds_wa;
	logic [31:0]    ds_wd;
	logic [DTW-1:0] dt_nx;
	logic           cs_we;
	logic [CAW-1:0] cs_wa;
	logic [31:0]    cs_wd;
	logic [CTW-1:0] ct_nx;
	logic [31:0]    fb_nx;
	logic           dm_we;
	logic           wr2_nx;
	logic           pv;
	logic [31:0]    pval;
	logic [32:0]    alc_end;
	logic [31:0]    alc_at;
	logic           halted_nx;

	assign ip_inc  = ip_q + PAB'(1);
	assign alc_end = {1'b0, 32'(ct_q)} + {1'b0, arg_q} + 33'd1;
	assign alc_at  = 32'(ct_q) + arg_q;

	always_comb begin
		err      = smeu_pkg::ERR_NONE;
		ip_nx    = ip_q;
		halt_now = 1'b0;
		ds_we    = 1'b0;
		ds_wa    = dt_q[DAW-1:0];
		ds_wd    = arg_q;
		dt_nx    = dt_q;
		cs_we    = 1'b0;
		cs_wa    = ct_q[CAW-1:0];
		cs_wd    = ds_t_q;
		ct_nx    = ct_q;
		fb_nx    = fb_q;
		dm_we    = 1'b0;
		wr2_nx   = 1'b0;
		pv       = 1'b0;
		pval     = 32'd0;
		if (!stopped_q) begin
			if (!budget_ok) begin
				err = smeu_pkg::ERR_BUDGET;
			end else begin
				case (op)
					smeu_pkg::OP_PUSH, smeu_pkg::OP_RCL, smeu_pkg::OP_RCE: begin
						if (dt_full) begin
							err = smeu_pkg::ERR_OVERFLOW;
						end else if (op == smeu_pkg::OP_RCL && !mok) begin
							err = smeu_pkg::ERR_INDEX;
						end else if (op == smeu_pkg::OP_RCE && !fok) begin
							err = smeu_pkg::ERR_INDEX;
						end else begin
							ds_we = 1'b1;
							ds_wd = (op == smeu_pkg::OP_PUSH) ? arg_q :
								(op == smeu_pkg::OP_RCL) ? dm_rd : cs_t_q;
							dt_nx = dt_q + DTW'(1);
							ip_nx = ip_inc;
						end
					end
					smeu_pkg::OP_POP, smeu_pkg::OP_PRN: begin
						if (dt_q == '0) begin
							err = smeu_pkg::ERR_UNDERFLOW;
						end else begin
							dt_nx = dt_m1;
							pv    = (op == smeu_pkg::OP_PRN);
							pval  = (op == smeu_pkg::OP_PRN) ? ds_t_q : 32'd0;
							ip_nx = ip_inc;
						end
					end
					smeu_pkg::OP_DUP: begin
						if (dt_q == '0) begin
							err = smeu_pkg::ERR_UNDERFLOW;
						end else if (dt_full) begin
							err = smeu_pkg::ERR_OVERFLOW;
						end else begin
							ds_we = 1'b1;
							ds_wd = ds_t_q;
							dt_nx = dt_q + DTW'(1);
							ip_nx = ip_inc;
						end
					end
					smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL,
					smeu_pkg::OP_DIV, smeu_pkg::OP_EQ, smeu_pkg::OP_GT,
					smeu_pkg::OP_GE, smeu_pkg::OP_LT, smeu_pkg::OP_LE,
					smeu_pkg::OP_NE: begin
						if (dt_q < DTW'(2)) begin
							err = smeu_pkg::ERR_UNDERFLOW;
						end else if (op == smeu_pkg::OP_DIV && ds_t_q == 32'd0) begin
							err = smeu_pkg::ERR_DIV_ZERO;
						end else begin
							ds_we = 1'b1;
							ds_wa = dt_m2[DAW-1:0];
							ds_wd = bin_r;
							dt_nx = dt_m1;
							ip_nx = ip_inc;
						end
					end
					smeu_pkg::OP_JMP: begin
						ip_nx = arg_q[PAB-1:0];
					end
					smeu_pkg::OP_JIT, smeu_pkg::OP_JIF: begin
						if (dt_q == '0) begin
							err = smeu_pkg::ERR_UNDERFLOW;
						end else begin
							dt_nx = dt_m1;
							ip_nx = ((ds_t_q != 32'd0) == (op == smeu_pkg::OP_JIT)) ?
								arg_q[PAB-1:0] : ip_inc;
						end
					end
					smeu_pkg::OP_CALL: begin
						if (({1'b0, ct_q} + (CTW + 1)'(2)) > (CTW + 1)'(CALL_STACK_DEPTH)) begin
							err = smeu_pkg::ERR_CALL;
						end else begin
							cs_we  = 1'b1;
							cs_wd  = 32'(ip_q);
							wr2_nx = 1'b1;
							ct_nx  = ct_q + CTW'(2);
							fb_nx  = 32'(ct_q) + 32'd2;
							ip_nx  = arg_q[PAB-1:0];
						end
					end
					smeu_pkg::OP_RET: begin
						if (ct_q < CTW'(2)) begin
							err = smeu_pkg::ERR_CALL;
						end else begin
							fb_nx = cs_t_q;
							ip_nx = cs_s_q[PAB-1:0] + PAB'(1);
							ct_nx = ct_m2;
						end
					end
					smeu_pkg::OP_STO: begin
						if (dt_q == '0) begin
							err = smeu_pkg::ERR_UNDERFLOW;
						end else if (!mok) begin
							err = smeu_pkg::ERR_INDEX;
						end else begin
							dm_we = 1'b1;
							dt_nx = dt_m1;
							ip_nx = ip_inc;
						end
					end
					smeu_pkg::OP_END: begin
						halt_now = 1'b1;
					end
					smeu_pkg::OP_STL: begin
						if (dt_q == '0) begin
							err = smeu_pkg::ERR_UNDERFLOW;
						end else if (!fok) begin
							err = smeu_pkg::ERR_INDEX;
						end else begin
							cs_we = 1'b1;
							cs_wa = fidx[CAW-1:0];
							cs_wd = ds_t_q;
							dt_nx = dt_m1;
							ip_nx = ip_inc;
						end
					end
					smeu_pkg::OP_ALC: begin
						if (arg_q[31] || alc_end > 33'(CALL_STACK_DEPTH)) begin
							err = smeu_pkg::ERR_CALL;
						end else begin
							cs_we = 1'b1;
							cs_wa = alc_at[CAW-1:0];
							cs_wd = arg_q;
							ct_nx = alc_end[CTW-1:0];
							ip_nx = ip_inc;
						end
					end
					smeu_pkg::OP_FRE: begin
						if (ct_q == '0 || cs_t_q > 32'(ct_m1)) begin
							err = smeu_pkg::ERR_CALL;
						end else begin
							ct_nx = ct_m1 - cs_t_q[CTW-1:0];
							ip_nx = ip_inc;
						end
					end
					default: begin
						err = smeu_pkg::ERR_OPCODE;
					end
				endcase
			end
		end
	end

	assign halted_nx = stopped_q || (err != smeu_pkg::ERR_NONE) || halt_now;

	// Latch the instruction beat
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			op_q  <= cmd.operation;
			arg_q <= cmd.argument;
		end
	end

	// Data stack: registered reads, one write port
	always_ff @(posedge clk) begin
		if (ctl.commit && ds_we) begin
			ds_mem[ds_wa] <= ds_wd;
		end
		if (ctl.rd_a) begin
			ds_t_q <= ds_mem[ds_ra];
		end
		if (ctl.rd_b) begin
			ds_s_q <= ds_mem[ds_ra];
		end
	end

	// Call stack: unwritten entries read as zero
	always_ff @(posedge clk) begin
		if (ctl.commit && cs_we) begin
			cs_mem[cs_wa] <= cs_wd;
		end else if (ctl.wr2) begin
			cs_mem[pend_wa_q] <= pend_wd_q;
		end
		if (ctl.rd_a) begin
			cs_t_q <= cs_vld_q[cs_ra] ? cs_mem[cs_ra] : 32'd0;
		end
		if (ctl.rd_b) begin
			cs_s_q <= cs_vld_q[cs_ra] ? cs_mem[cs_ra] : 32'd0;
		end
		if (ctl.commit) begin
			pend_wa_q <= CAW'(ct_q + CTW'(1));
			pend_wd_q <= fb_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_vld_q <= '0;
		end else if (ctl.commit && cs_we) begin
			cs_vld_q[cs_wa] <= 1'b1;
		end else if (ctl.wr2) begin
			cs_vld_q[pend_wa_q] <= 1'b1;
		end
	end

	// Data memory and machine registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MEM_WORDS; i++) begin
				dm_q[i] <= 32'd0;
			end
			dt_q      <= '0;
			ct_q      <= '0;
			fb_q      <= 32'd0;
			ip_q      <= '0;
			sc_q      <= 16'd0;
			stopped_q <= 1'b0;
		end else if (ctl.commit) begin
			if (dm_we) begin
				dm_q[arg_q[MAW-1:0]] <= ds_t_q;
			end
			dt_q      <= dt_nx;
			ct_q      <= ct_nx;
			fb_q      <= fb_nx;
			ip_q      <= ip_nx;
			stopped_q <= halted_nx;
			if (!stopped_q && err == smeu_pkg::ERR_NONE && sc_q != smeu_pkg::STEP_COUNT_MAX) begin
				sc_q <= sc_q + 16'd1;
			end
		end
	end

	// Result register: load on commit, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			rsp_q.next_address <= ip_nx;
			rsp_q.print_valid  <= pv;
			rsp_q.print_value  <= pval;
			rsp_q.halted       <= halted_nx;
			rsp_q.error_code   <= err;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign sts.need_div = !stopped_q && budget_ok && (op == smeu_pkg::OP_DIV) &&
		(dt_q >= DTW'(2)) && (ds_t_q != 32'd0);
	assign sts.div_done = div_done;
	assign sts.out_free = !rsp_valid_q || rsp_ready;
	assign sts.need_wr2 = wr2_nx;

endmodule
`default_nettype wire

>>> rtl/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit with its configuration port.
//
// Usage: each cmd beat carries one fetched instruction (operation, argument).
// The unit executes it against its data stack, call stack, data memory and
// instruction pointer, and returns one rsp beat with the next fetch address,
// an optional printed value, the halted flag and an error code.
// Sequence: accept, read of the top operand, read of the second operand
// (stack memories have registered reads), prepare, then commit into the
// registered output; CALL adds a second call stack write on the single write
// port, and DIV waits for the bit-serial divider between prepare and commit.
// cmd_ready is high only while no item is in flight. A result waits in the
// output register; if rsp_ready stays low the unit holds the next commit.
// Reset clears stacks pointers, the call stack and data memory (via valid
// bits and reset flops, no clearing pass), instruction pointer, step count
// and the stopped flag; step_limit returns to 1000.
// Register 0 at byte address 0: step_limit[15:0], written over APB.
`default_nettype none
module stack_machine_execute_unit #(
	parameter int DATA_STACK_DEPTH = 64,
	parameter int CALL_STACK_DEPTH = 64,
	parameter int MEM_WORDS        = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  wire smeu_pkg::instr_t  cmd,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output smeu_pkg::result_t      rsp,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	smeu_pkg::ctrl_cmd_t ctl;
	smeu_pkg::ctrl_sts_t sts;
	logic [15:0]         step_limit_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_limit_q <= smeu_pkg::STEP_LIMIT_RESET;
		end else if (psel && penable && pwrite && paddr[2] == smeu_pkg::REG_STEP_LIMIT) begin
			step_limit_q <= pwdata[15:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == smeu_pkg::REG_STEP_LIMIT) ? {16'd0, step_limit_q} : 32'd0;

	smeu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	smeu_dpath #(
		.DATA_STACK_DEPTH (DATA_STACK_DEPTH),
		.CALL_STACK_DEPTH (CALL_STACK_DEPTH),
		.MEM_WORDS        (MEM_WORDS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.cmd        (cmd),
		.step_limit (step_limit_q),
		.rsp        (rsp),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready)
	);

endmodule
`default_nettype wire

>>> rtl/smeu_checker.sv
// Port-level assertions for the execute unit and their bind.
`default_nettype none
module smeu_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cmd_valid,
	input wire logic              cmd_ready,
	input wire smeu_pkg::instr_t  cmd,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire smeu_pkg::result_t rsp
);

	// A stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// One item in flight: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("second item accepted while busy");

	// An error always stops the machine
	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.error_code != smeu_pkg::ERR_NONE |-> rsp.halted)
		else $error("error reported without halt");

	// A print only comes from a clean, running step
	a_print_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.print_valid |-> rsp.error_code == smeu_pkg::ERR_NONE && !rsp.halted)
		else $error("print on a faulted or halted step");

endmodule

bind stack_machine_execute_unit smeu_checker u_smeu_checker (.*);
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the stack machine execute unit.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

	// Track the machine state, predict each result beat and match it on arrival
	class scoreboard;
		logic [31:0] dstk[64];
		logic [31:0] cstk[64];
		logic [31:0] dmem[16];
		int unsigned dtop, ctop;
		logic [31:0] fbase;
		logic [11:0] ip;
		int unsigned steps, limit;
		bit stopped;
		smeu_pkg::result_t pending_results[$];
		int errors;
		int accepted;

		function new();
			foreach (dstk[i]) dstk[i] = '0;
			foreach (cstk[i]) cstk[i] = '0;
			foreach (dmem[i]) dmem[i] = '0;
			dtop = 0; ctop = 0; fbase = '0; ip = '0;
			steps = 0; limit = 1000; stopped = 0;
			errors = 0; accepted = 0;
		endfunction

		function void set_limit(logic [15:0] v);
			limit = v;
		endfunction

		function logic [31:0] alu(smeu_pkg::opcode_t op, logic [31:0] b, logic [31:0] t);
			longint sb, st;
			sb = longint'($signed(b));
			st = longint'($signed(t));
			case (op)
				smeu_pkg::OP_ADD: return b + t;
				smeu_pkg::OP_SUB: return b - t;
				smeu_pkg::OP_MUL: return b * t;
				smeu_pkg::OP_DIV: return 32'(sb / st);
				smeu_pkg::OP_EQ:  return {31'b0, sb == st};
				smeu_pkg::OP_GT:  return {31'b0, sb > st};
				smeu_pkg::OP_GE:  return {31'b0, sb >= st};
				smeu_pkg::OP_LT:  return {31'b0, sb < st};
				smeu_pkg::OP_LE:  return {31'b0, sb <= st};
				default: return {31'b0, sb != st};
			endcase
		endfunction

		// Execute one instruction on the model state and queue its result beat
		function void note_instr(smeu_pkg::instr_t it);
			smeu_pkg::result_t r;
			smeu_pkg::error_t err;
			logic [31:0] arg, v;
			longint sarg, fidx;
			bit fok, mok, halt_now, pv;
			logic [31:0] pval;
			logic [11:0] nxt;
			smeu_pkg::opcode_t op;
			accepted++;
			op = smeu_pkg::opcode_t'(it.operation);
			arg = it.argument;
			sarg = longint'($signed(arg));
			fidx = longint'(fbase) + sarg;
			fok = fidx >= 0 && fidx < 64;
			mok = sarg >= 0 && sarg < 16;
			err = smeu_pkg::ERR_NONE; halt_now = 0; pv = 0; pval = '0;
			nxt = ip + 12'd1;
			if (!stopped) begin
				if (steps >= limit) begin
					err = smeu_pkg::ERR_BUDGET;
				end else begin
					case (it.operation)
						smeu_pkg::OP_PUSH, smeu_pkg::OP_RCL, smeu_pkg::OP_RCE: begin
							if (dtop >= 64) err = smeu_pkg::ERR_OVERFLOW;
							else if (op == smeu_pkg::OP_RCL && !mok) err = smeu_pkg::ERR_INDEX;
							else if (op == smeu_pkg::OP_RCE && !fok) err = smeu_pkg::ERR_INDEX;
							else begin
								dstk[dtop] = op == smeu_pkg::OP_PUSH ? arg :
									op == smeu_pkg::OP_RCL ? dmem[sarg] : cstk[fidx];
								dtop++;
								ip = nxt;
							end
						end
						smeu_pkg::OP_POP, smeu_pkg::OP_PRN: begin
							if (dtop < 1) err = smeu_pkg::ERR_UNDERFLOW;
							else begin
								dtop--;
								if (op == smeu_pkg::OP_PRN) begin
									pv = 1; pval = dstk[dtop];
								end
								ip = nxt;
							end
						end
						smeu_pkg::OP_DUP: begin
							if (dtop < 1) err = smeu_pkg::ERR_UNDERFLOW;
							else if (dtop >= 64) err = smeu_pkg::ERR_OVERFLOW;
							else begin
								dstk[dtop] = dstk[dtop-1];
								dtop++;
								ip = nxt;
							end
						end
						smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL,
						smeu_pkg::OP_DIV, smeu_pkg::OP_EQ, smeu_pkg::OP_GT,
						smeu_pkg::OP_GE, smeu_pkg::OP_LT, smeu_pkg::OP_LE,
						smeu_pkg::OP_NE: begin
							if (dtop < 2) err = smeu_pkg::ERR_UNDERFLOW;
							else if (op == smeu_pkg::OP_DIV && dstk[dtop-1] == 0)
								err = smeu_pkg::ERR_DIV_ZERO;
							else begin
								v = alu(op, dstk[dtop-2], dstk[dtop-1]);
								dtop--;
								dstk[dtop-1] = v;
								ip = nxt;
							end
						end
						smeu_pkg::OP_JMP: ip = arg[11:0];
						smeu_pkg::OP_JIT, smeu_pkg::OP_JIF: begin
							if (dtop < 1) err = smeu_pkg::ERR_UNDERFLOW;
							else begin
								dtop--;
								ip = ((dstk[dtop] != 0) == (op == smeu_pkg::OP_JIT)) ?
									arg[11:0] : nxt;
							end
						end
						smeu_pkg::OP_CALL: begin
							if (ctop + 2 > 64) err = smeu_pkg::ERR_CALL;
							else begin
								cstk[ctop] = {20'b0, ip};
								cstk[ctop+1] = fbase;
								ctop += 2;
								fbase = ctop;
								ip = arg[11:0];
							end
						end
						smeu_pkg::OP_RET: begin
							if (ctop < 2) err = smeu_pkg::ERR_CALL;
							else begin
								fbase = cstk[ctop-1];
								ip = cstk[ctop-2][11:0] + 12'd1;
								ctop -= 2;
							end
						end
						smeu_pkg::OP_STO: begin
							if (dtop < 1) err = smeu_pkg::ERR_UNDERFLOW;
							else if (!mok) err = smeu_pkg::ERR_INDEX;
							else begin
								dtop--;
								dmem[sarg] = dstk[dtop];
								ip = nxt;
							end
						end
						smeu_pkg::OP_END: halt_now = 1;
						smeu_pkg::OP_STL: begin
							if (dtop < 1) err = smeu_pkg::ERR_UNDERFLOW;
							else if (!fok) err = smeu_pkg::ERR_INDEX;
							else begin
								dtop--;
								cstk[fidx] = dstk[dtop];
								ip = nxt;
							end
						end
						smeu_pkg::OP_ALC: begin
							if (sarg < 0 || longint'(ctop) + sarg + 1 > 64)
								err = smeu_pkg::ERR_CALL;
							else begin
								ctop += int'(sarg);
								cstk[ctop] = arg;
								ctop++;
								ip = nxt;
							end
						end
						smeu_pkg::OP_FRE: begin
							if (ctop < 1 || cstk[ctop-1] > ctop - 1) err = smeu_pkg::ERR_CALL;
							else ctop = ctop - 1 - cstk[ctop-1];
						end
						default: err = smeu_pkg::ERR_OPCODE;
					endcase
					if (op == smeu_pkg::OP_FRE && err == smeu_pkg::ERR_NONE) ip = nxt;
					if (err == smeu_pkg::ERR_NONE && steps < 32'hFFFF) steps++;
				end
				if (err != smeu_pkg::ERR_NONE || halt_now) stopped = 1;
			end
			r.next_address = ip;
			r.print_valid = pv;
			r.print_value = pval;
			r.halted = stopped;
			r.error_code = err;
			pending_results.push_back(r);
		endfunction

		// Compare one result beat with the oldest prediction
		function void check_result(smeu_pkg::result_t got);
			smeu_pkg::result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.next_address !== want.next_address) begin
				$display("%0t: next_address expected %h actual %h", $time,
					want.next_address, got.next_address);
				errors++;
			end
			if (got.print_valid !== want.print_valid) begin
				$display("%0t: print_valid expected %b actual %b", $time,
					want.print_valid, got.print_valid);
				errors++;
			end
			if (got.print_value !== want.print_value) begin
				$display("%0t: print_value expected %h actual %h", $time,
					want.print_value, got.print_value);
				errors++;
			end
			if (got.halted !== want.halted) begin
				$display("%0t: halted expected %b actual %b", $time, want.halted, got.halted);
				errors++;
			end
			if (got.error_code !== want.error_code) begin
				$display("%0t: error_code expected %0d actual %0d", $time,
					want.error_code, got.error_code);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cmd_valid, cmd_ready, rsp_valid, rsp_ready;
	smeu_pkg::instr_t cmd;
	smeu_pkg::result_t rsp;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	scoreboard sb = new();
	int idle_cycles = 0;
	bit stall_done;

	stack_machine_execute_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'h1;
			2: return 32'hFFFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'h7FFF_FFFF;
			5: return $urandom_range(0, 20);
			default: return $urandom;
		endcase
	endfunction

	// Build an instruction that the current state executes without a fault
	function automatic smeu_pkg::instr_t legal_instr();
		smeu_pkg::instr_t it;
		smeu_pkg::opcode_t op;
		int unsigned dt, ct;
		bit ok;
		dt = sb.dtop;
		ct = sb.ctop;
		op = smeu_pkg::opcode_t'($urandom_range(0, 25));
		if (op == smeu_pkg::OP_END) op = smeu_pkg::OP_PUSH;
		// steer the data stack away from its ends
		if (dt > 48 && $urandom_range(0, 1)) op = smeu_pkg::OP_POP;
		if (dt < 3 && $urandom_range(0, 1)) op = smeu_pkg::OP_PUSH;
		it.operation = op;
		it.argument = pick_word();
		case (op)
			smeu_pkg::OP_PUSH, smeu_pkg::OP_DUP:
				ok = dt < 64 && (op == smeu_pkg::OP_PUSH || dt >= 1);
			smeu_pkg::OP_POP, smeu_pkg::OP_PRN, smeu_pkg::OP_JIT, smeu_pkg::OP_JIF:
				ok = dt >= 1;
			smeu_pkg::OP_DIV: ok = dt >= 2 && sb.dstk[dt-1] != 0;
			smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_EQ,
			smeu_pkg::OP_GT, smeu_pkg::OP_GE, smeu_pkg::OP_LT, smeu_pkg::OP_LE,
			smeu_pkg::OP_NE:
				ok = dt >= 2;
			smeu_pkg::OP_JMP: ok = 1;
			smeu_pkg::OP_CALL: ok = ct + 2 <= 64;
			smeu_pkg::OP_RET: ok = ct >= 2;
			smeu_pkg::OP_STO, smeu_pkg::OP_RCL: begin
				ok = op == smeu_pkg::OP_STO ? dt >= 1 : dt < 64;
				it.argument = $urandom_range(0, 15);
			end
			smeu_pkg::OP_STL, smeu_pkg::OP_RCE: begin
				// a frame base restored from stored data may lie outside the stack
				ok = (op == smeu_pkg::OP_STL ? dt >= 1 : dt < 64) && sb.fbase < 64;
				it.argument = $urandom_range(0, 63) - sb.fbase;
			end
			smeu_pkg::OP_ALC: begin
				ok = ct < 64;
				if (ok) it.argument = $urandom_range(0, (63 - ct) > 4 ? 4 : 63 - ct);
			end
			default: ok = ct >= 1 && sb.cstk[ct-1] <= ct - 1;
		endcase
		if (!ok) begin
			it.operation = dt < 64 ? smeu_pkg::OP_PUSH : smeu_pkg::OP_POP;
			it.argument = pick_word();
		end
		return it;
	endfunction

	// Offer one beat after a random gap and hold it until accepted
	task automatic send_instr(smeu_pkg::instr_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= it;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		sb.note_instr(it);
	endtask

	task automatic send_op(smeu_pkg::opcode_t op, logic [31:0] arg);
		smeu_pkg::instr_t it;
		it.operation = op;
		it.argument = arg;
		send_instr(it);
	endtask

	// Drain all outstanding results, then let the unit settle
	task automatic drain();
		cmd_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Write step_limit over APB and read it back
	task automatic write_limit(logic [15:0] v);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= 3'(smeu_pkg::REG_STEP_LIMIT) << 2;
		pwdata <= {16'($urandom_range(0, 65535)), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_limit(v);
		pwrite <= 1'b0; penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {16'b0, v}) begin
			$display("%0t: step_limit readback expected %h actual %h", $time,
				{16'b0, v}, prdata);
			sb.errors++;
		end
		psel <= 1'b0; penable <= 1'b0;
		@(posedge clk);
	endtask

	// Receiver: random backpressure plus one long hold-off
	initial begin
		int gap;
		rsp_ready = 1'b0;
		stall_done = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!stall_done && sb.accepted >= 300) begin
				stall_done = 1;
				rsp_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Check each accepted result beat
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) sb.check_result(rsp);
	end

	// Watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		smeu_pkg::instr_t it;
		int pick;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_limit(16'hFFFF);

		// Directed: operand extremes and most operations
		send_op(smeu_pkg::OP_PUSH, 32'h7FFF_FFFF);
		send_op(smeu_pkg::OP_PUSH, 32'h8000_0000);
		send_op(smeu_pkg::OP_PUSH, 32'hFFFF_FFFF);
		send_op(smeu_pkg::OP_DIV, 32'h0);
		send_op(smeu_pkg::OP_DUP, 32'h0);
		send_op(smeu_pkg::OP_ADD, 32'h0);
		send_op(smeu_pkg::OP_LE, 32'h0);
		send_op(smeu_pkg::OP_PUSH, 32'd3);
		send_op(smeu_pkg::OP_MUL, 32'h0);
		send_op(smeu_pkg::OP_PUSH, 32'd5);
		send_op(smeu_pkg::OP_SUB, 32'h0);
		send_op(smeu_pkg::OP_STO, 32'd15);
		send_op(smeu_pkg::OP_RCL, 32'd15);
		send_op(smeu_pkg::OP_RCL, 32'd0);
		send_op(smeu_pkg::OP_JIF, 32'd100);
		send_op(smeu_pkg::OP_PRN, 32'h0);
		send_op(smeu_pkg::OP_CALL, 32'd200);
		send_op(smeu_pkg::OP_ALC, 32'd0);
		send_op(smeu_pkg::OP_RCE, 32'd0);
		send_op(smeu_pkg::OP_STL, 32'd1);
		send_op(smeu_pkg::OP_FRE, 32'h0);
		send_op(smeu_pkg::OP_PUSH, 32'd1);
		send_op(smeu_pkg::OP_JIT, 32'd300);
		send_op(smeu_pkg::OP_RET, 32'h0);
		send_op(smeu_pkg::OP_JMP, 32'hFFFF_FFFF);

		// Random well-formed programs in three phases, under limits 0xFFFF, 60000 and 0xFFFF
		for (int phase = 0; phase < 3; phase++) begin
			for (int n = 0; n < 615; n++) send_instr(legal_instr());
			drain();
			if (phase == 0) write_limit(16'd60000);
			else if (phase == 1) write_limit(16'hFFFF);
		end

		// Finish the run with one stopping case
		pick = $urandom_range(0, 3);
		write_limit(16'd0);
		if (pick != 0) write_limit(16'hFFFF);
		case (pick)
			0: send_op(smeu_pkg::OP_PUSH, 32'h1);
			1: send_op(smeu_pkg::OP_END, $urandom);
			2: begin
				it.operation = 5'($urandom_range(26, 31));
				it.argument = $urandom;
				send_instr(it);
			end
			default: begin
				if (sb.dtop >= 63) send_op(smeu_pkg::OP_POP, 32'h0);
				send_op(smeu_pkg::OP_PUSH, 32'h0);
				send_op(smeu_pkg::OP_DIV, 32'h0);
			end
		endcase
		// Ignored beats after the stop
		for (int n = 0; n < 8; n++) begin
			it.operation = 5'($urandom);
			it.argument = $urandom;
			send_instr(it);
		end
		drain();
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire
